@@ rtl/tipu_pkg.sv @@
// Shared types and constants for the triangular index pack/unpack unit.
package tipu_pkg;

  localparam int MAX_DIM_DEF = 65535;
  localparam logic [15:0] DIM_RESET = 16'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DIM   = 3'd1,
    ST_BAD_FIRST = 3'd2,
    ST_BAD_SECOND = 3'd3,
    ST_ABOVE_N   = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_t;

  typedef enum logic {
    OP_PACK   = 1'b0,
    OP_UNPACK = 1'b1
  } opcode_t;

  // Control that travels with an item down the chain.
  typedef struct packed {
    logic    valid;
    opcode_t op;
    status_t status;
  } ctl_t;

endpackage

@@ rtl/tipu_front.sv @@
// Input stage: checks an item, orders the coordinates and registers it.
module tipu_front
  import tipu_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int KW      = $clog2(MAX_DIM + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [15:0]   dim,
  input  logic          take,
  input  logic          in_opcode,
  input  logic [15:0]   in_first_coord,
  input  logic [15:0]   in_second_coord,
  input  logic [31:0]   in_packed_in,
  output ctl_t          ctl_r,
  output logic [31:0]   idx_r,
  output logic [15:0]   col_r,
  output logic [KW-1:0] ktgt_r
);

  ctl_t          ctl_nxt;
  logic [32:0]   tri_prod;
  logic [15:0]   r_min;
  logic [15:0]   c_max;

  assign tri_prod = 33'(dim) * 33'({1'b0, dim} + 17'd1);
  assign r_min    = (in_first_coord < in_second_coord) ? in_first_coord : in_second_coord;
  assign c_max    = (in_first_coord < in_second_coord) ? in_second_coord : in_first_coord;

  always_comb begin
    ctl_nxt.valid  = take;
    ctl_nxt.op     = opcode_t'(in_opcode);
    ctl_nxt.status = ST_OK;
    if ((dim == 16'd0) || ({16'd0, dim} > 32'(MAX_DIM))) begin
      ctl_nxt.status = ST_BAD_DIM;
    end else if (ctl_nxt.op == OP_PACK) begin
      if (in_first_coord == 16'd0) begin
        ctl_nxt.status = ST_BAD_FIRST;
      end else if (in_second_coord == 16'd0) begin
        ctl_nxt.status = ST_BAD_SECOND;
      end else if ((in_first_coord > dim) || (in_second_coord > dim)) begin
        ctl_nxt.status = ST_ABOVE_N;
      end
    end else begin
      if ((in_packed_in == 32'd0) || (in_packed_in > tri_prod[32:1])) begin
        ctl_nxt.status = ST_BAD_INDEX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r  <= in_packed_in;
      col_r  <= c_max;
      ktgt_r <= KW'(r_min - 16'd1);
    end
  end

endmodule

@@ rtl/tipu_cell.sv @@
// One cell of the chain: decides one bit of the row offset.
module tipu_cell
  import tipu_pkg::*;
#(
  parameter int KW  = 16,
  parameter int PW  = 2 * KW + 1,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [15:0]   dim,
  input  ctl_t          ctl_in,
  input  logic [31:0]   idx_in,
  input  logic [15:0]   col_in,
  input  logic [KW-1:0] ktgt_in,
  input  logic [KW-1:0] k_in,
  input  logic [PW-1:0] p_in,
  input  logic [PW-1:0] q_in,
  output ctl_t          ctl_r,
  output logic [31:0]   idx_r,
  output logic [15:0]   col_r,
  output logic [KW-1:0] ktgt_r,
  output logic [KW-1:0] k_r,
  output logic [PW-1:0] p_r,
  output logic [PW-1:0] q_r
);

  logic [KW-1:0] k_try;
  logic [PW-1:0] p_try;
  logic [PW-1:0] q_try;
  logic [PW-1:0] s_try;
  logic          set_bit;

  // Lower bits of k are still zero, so setting this bit adds 2^BIT.
  // p tracks k*N and q tracks k*k, updated by shifts and adds only.
  assign k_try = k_in | (KW'(1) << BIT);
  assign p_try = p_in + (PW'(dim) << BIT);
  assign q_try = q_in + (PW'(k_in) << (BIT + 1)) + (PW'(1) << (2 * BIT));
  assign s_try = p_try - ((q_try - PW'(k_try)) >> 1);

  always_comb begin
    if (ctl_in.op == OP_PACK) begin
      set_bit = ktgt_in[BIT];
    end else begin
      set_bit = (PW'(k_try) < PW'(dim)) && (s_try < PW'(idx_in));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r  <= idx_in;
      col_r  <= col_in;
      ktgt_r <= ktgt_in;
      k_r    <= set_bit ? k_try : k_in;
      p_r    <= set_bit ? p_try : p_in;
      q_r    <= set_bit ? q_try : q_in;
    end
  end

endmodule

@@ rtl/tipu_back.sv @@
// Output stage: forms the result fields from the row offset and holds the item.
module tipu_back
  import tipu_pkg::*;
#(
  parameter int KW = 16,
  parameter int PW = 2 * KW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  ctl_t          ctl_in,
  input  logic [31:0]   idx_in,
  input  logic [15:0]   col_in,
  input  logic [KW-1:0] k_in,
  input  logic [PW-1:0] p_in,
  input  logic [PW-1:0] q_in,
  output logic          out_valid_r,
  output logic [31:0]   out_packed_r,
  output logic [15:0]   out_row_r,
  output logic [15:0]   out_col_r,
  output status_t       out_status_r
);

  logic [PW-1:0] row_start;
  logic [PW-1:0] packed_sum;
  logic [PW-1:0] col_sum;
  logic          ok;

  // Elements before row k+1: k*N - k*(k-1)/2.
  assign row_start  = p_in - ((q_in - PW'(k_in)) >> 1);
  assign packed_sum = row_start + PW'(col_in) - PW'(k_in);
  assign col_sum    = PW'(idx_in) - row_start + PW'(k_in);
  assign ok         = (ctl_in.status == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= ctl_in.status;
      out_packed_r <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      if (ok && (ctl_in.op == OP_PACK)) begin
        out_packed_r <= packed_sum[31:0];
      end else if (ok) begin
        out_row_r <= 16'(k_in) + 16'd1;
        out_col_r <= col_sum[15:0];
      end
    end
  end

endmodule

@@ rtl/triangular_index_pack_unpack_unit.sv @@
// Top level: packed upper-triangular index translator built as a chain of cells.
// The chain is one input stage, one cell per bit of the row offset, one output register.
// Throughput is one item per cycle; the whole chain holds while a result waits.
// Synchronous active-low reset empties the chain and sets the dimension to 1.
module triangular_index_pack_unpack_unit
  import tipu_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_dimension,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_first_coord,
  input  logic [15:0] in_second_coord,
  input  logic [31:0] in_packed_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_packed_out,
  output logic [15:0] out_row_out,
  output logic [15:0] out_column_out,
  output logic [2:0]  out_status
);

  localparam int KW = $clog2(MAX_DIM + 1);
  localparam int PW = 2 * KW + 1;

  logic [15:0] dim_r;
  logic        adv;
  status_t     status_r;

  ctl_t          ctl_s  [KW+1];
  logic [31:0]   idx_s  [KW+1];
  logic [15:0]   col_s  [KW+1];
  logic [KW-1:0] ktgt_s [KW+1];
  logic [KW-1:0] k_s    [KW+1];
  logic [PW-1:0] p_s    [KW+1];
  logic [PW-1:0] q_s    [KW+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dim_r <= cfg_dimension;
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  tipu_front #(.MAX_DIM(MAX_DIM), .KW(KW)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .dim             (dim_r),
    .take            (in_valid && !in_stall),
    .in_opcode       (in_opcode),
    .in_first_coord  (in_first_coord),
    .in_second_coord (in_second_coord),
    .in_packed_in    (in_packed_in),
    .ctl_r           (ctl_s[0]),
    .idx_r           (idx_s[0]),
    .col_r           (col_s[0]),
    .ktgt_r          (ktgt_s[0])
  );

  assign k_s[0] = '0;
  assign p_s[0] = '0;
  assign q_s[0] = '0;

  // Cell j decides bit KW-1-j of the row offset, most significant first.
  for (genvar j = 0; j < KW; j++) begin : g_cell
    tipu_cell #(.KW(KW), .PW(PW), .BIT(KW - 1 - j)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .dim     (dim_r),
      .ctl_in  (ctl_s[j]),
      .idx_in  (idx_s[j]),
      .col_in  (col_s[j]),
      .ktgt_in (ktgt_s[j]),
      .k_in    (k_s[j]),
      .p_in    (p_s[j]),
      .q_in    (q_s[j]),
      .ctl_r   (ctl_s[j+1]),
      .idx_r   (idx_s[j+1]),
      .col_r   (col_s[j+1]),
      .ktgt_r  (ktgt_s[j+1]),
      .k_r     (k_s[j+1]),
      .p_r     (p_s[j+1]),
      .q_r     (q_s[j+1])
    );
  end

  tipu_back #(.KW(KW), .PW(PW)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .ctl_in       (ctl_s[KW]),
    .idx_in       (idx_s[KW]),
    .col_in       (col_s[KW]),
    .k_in         (k_s[KW]),
    .p_in         (p_s[KW]),
    .q_in         (q_s[KW]),
    .out_valid_r  (out_valid),
    .out_packed_r (out_packed_out),
    .out_row_r    (out_row_out),
    .out_col_r    (out_column_out),
    .out_status_r (status_r)
  );

  assign out_status = status_r;

endmodule

@@ test/triangular_index_pack_unpack_unit_test.sv @@
// Self-checking testbench for the triangular index pack/unpack unit.
`timescale 1ns / 100ps

module triangular_index_pack_unpack_unit_test
  import tipu_pkg::*;
();

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic [31:0] pidx;
    logic [15:0] row;
    logic [15:0] column;
    status_t     status;
  } xlate_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_dimension = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = 1'b0;
  logic [15:0] in_first_coord = 16'd0;
  logic [15:0] in_second_coord = 16'd0;
  logic [31:0] in_packed_in = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_packed_out;
  logic [15:0] out_row_out;
  logic [15:0] out_column_out;
  logic [2:0]  out_status;

  xlate_result_t pending_results[$];
  logic [15:0]   dimension_model = DIM_RESET;
  int            fault_count = 0;
  int            tx_idle_pct = 0;
  int            rx_idle_pct = 0;
  logic          hold_req = 1'b0;
  int            hold_count = 0;
  int            quiet_cycles = 0;

  triangular_index_pack_unpack_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_dimension   (cfg_dimension),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_first_coord  (in_first_coord),
    .in_second_coord (in_second_coord),
    .in_packed_in    (in_packed_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_out  (out_packed_out),
    .out_row_out     (out_row_out),
    .out_column_out  (out_column_out),
    .out_status      (out_status)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Number of elements stored in the rows above row r of an n by n upper triangle.
  function automatic longint unsigned rows_before(input longint unsigned r,
                                                  input longint unsigned n);
    longint unsigned k;
    k = r - 1;
    return k * n - ((k == 0) ? 0 : (k * (k - 1)) / 2);
  endfunction

  function automatic xlate_result_t translate_expected(input logic [15:0] dim,
                                                       input opcode_t op,
                                                       input logic [15:0] a,
                                                       input logic [15:0] b,
                                                       input logic [31:0] idx);
    xlate_result_t res;
    longint unsigned n, r, c, lo, hi, mid, total;
    res = '{32'd0, 16'd0, 16'd0, ST_OK};
    n = 64'(dim);
    if (n == 0 || n > MAX_DIM_DEF) begin
      res.status = ST_BAD_DIM;
    end else if (op == OP_PACK) begin
      if (a == 0) begin
        res.status = ST_BAD_FIRST;
      end else if (b == 0) begin
        res.status = ST_BAD_SECOND;
      end else if (a > n || b > n) begin
        res.status = ST_ABOVE_N;
      end else begin
        r = 64'((a < b) ? a : b);
        c = 64'((a < b) ? b : a);
        res.pidx = 32'(rows_before(r, n) + (c - r) + 1);
      end
    end else begin
      total = n * (n + 1) / 2;
      if (idx == 0 || idx > total) begin
        res.status = ST_BAD_INDEX;
      end else begin
        // The row is the last one whose first element lies at or below the index.
        lo = 1;
        hi = n;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (rows_before(mid, n) < idx) lo = mid;
          else hi = mid - 1;
        end
        res.row = 16'(lo);
        res.column = 16'(64'(idx) - rows_before(lo, n) + lo - 1);
      end
    end
    return res;
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Result side: random stall, or one long hold-off while hold_req is up.
  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
      if (!hold_req) hold_count <= 0;
    end
  end

  always @(posedge clk) begin
    xlate_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_fault($sformatf("unexpected item: index %0d row %0d column %0d status %0d",
                             out_packed_out, out_row_out, out_column_out, out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_packed_out !== want.pidx || out_row_out !== want.row ||
            out_column_out !== want.column || out_status !== want.status) begin
          note_fault($sformatf(
              "mismatch: expected index %0d row %0d column %0d status %0d, got %0d %0d %0d %0d",
              want.pidx, want.row, want.column, want.status,
              out_packed_out, out_row_out, out_column_out, out_status));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and returns at the edge where it is accepted.
  task automatic send_item(input opcode_t op, input logic [15:0] a, input logic [15:0] b,
                           input logic [31:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_first_coord <= a;
    in_second_coord <= b;
    in_packed_in <= idx;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(translate_expected(dimension_model, op, a, b, idx));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_dimension(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_dimension <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dimension_model = value;
  endtask

  task automatic send_random_item();
    opcode_t         op;
    logic [15:0]     a, b;
    logic [31:0]     idx;
    longint unsigned n, total, r;
    int              pick;
    n = 64'(dimension_model);
    total = n * (n + 1) / 2;
    op = opcode_t'($urandom_range(1));
    a = 16'($urandom);
    b = 16'($urandom);
    idx = $urandom;
    pick = $urandom_range(99);
    if (op == OP_PACK) begin
      if (n != 0 && pick < 80) begin
        a = 16'($urandom_range(32'(n), 1));
        b = 16'($urandom_range(32'(n), 1));
        if (pick < 8) a = 16'(n);
        else if (pick < 16) b = 1;
        else if (pick < 22) b = a;
      end else if (pick < 88) begin
        if ($urandom_range(1)) a = 16'd0;
        else b = 16'd0;
      end else if (pick < 94 && n < 65535) begin
        if ($urandom_range(1)) a = 16'($urandom_range(65535, 32'(n + 1)));
        else b = 16'($urandom_range(65535, 32'(n + 1)));
      end
    end else begin
      if (n != 0 && pick < 30) begin
        // Land on the first or last element of a row.
        r = 64'($urandom_range(32'(n), 1));
        idx = 32'($urandom_range(1) ? rows_before(r, n) + 1 : rows_before(r + 1, n));
      end else if (n != 0 && pick < 80) begin
        idx = $urandom_range(32'(total), 1);
      end else if (pick < 88) begin
        idx = $urandom_range(1) ? 32'd0 : 32'(total + 1);
      end
    end
    send_item(op, a, b, idx);
  endtask

  task automatic test_directed();
    // Reset dimension of one.
    send_item(OP_PACK, 16'd1, 16'd1, 32'd0);
    send_item(OP_UNPACK, 16'd0, 16'd0, 32'd1);
    send_item(OP_UNPACK, 16'd1, 16'd1, 32'd0);
    send_item(OP_UNPACK, 16'd0, 16'd0, 32'd2);
    send_item(OP_PACK, 16'd0, 16'd1, 32'd0);
    send_item(OP_PACK, 16'd1, 16'd0, 32'd0);
    send_item(OP_PACK, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send_item(OP_PACK, 16'd2, 16'd1, 32'd0);
    drain();
    write_dimension(16'd0);
    send_item(OP_PACK, 16'd1, 16'd1, 32'd0);
    send_item(OP_UNPACK, 16'd1, 16'd1, 32'd1);
    drain();
    write_dimension(16'hFFFF);
    send_item(OP_PACK, 16'hFFFF, 16'hFFFF, 32'd0);
    send_item(OP_PACK, 16'hFFFF, 16'd1, 32'd0);
    send_item(OP_PACK, 16'd1, 16'hFFFF, 32'd0);
    send_item(OP_PACK, 16'hFFFF, 16'd0, 32'd0);
    send_item(OP_UNPACK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_UNPACK, 16'd0, 16'd0, 32'd2147516416);
    send_item(OP_UNPACK, 16'd0, 16'd0, 32'd2147516417);
    send_item(OP_UNPACK, 16'd0, 16'd0, 32'd65535);
    send_item(OP_UNPACK, 16'd0, 16'd0, 32'd65536);
    drain();
    write_dimension(16'd5);
    send_item(OP_PACK, 16'd3, 16'd2, 32'd0);
    send_item(OP_PACK, 16'd6, 16'd1, 32'd0);
    send_item(OP_UNPACK, 16'd0, 16'd0, 32'd15);
    send_item(OP_UNPACK, 16'd0, 16'd0, 32'd16);
    drain();
  endtask

  // The result side holds off long enough for the chain to fill and stall its input.
  task automatic test_backpressure();
    write_dimension(16'd40);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= 1'b1;
    repeat (60) send_random_item();
    hold_req <= 1'b0;
    drain();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [15:0] d0, input logic [15:0] d1,
                                     input logic [15:0] d2, input logic [15:0] d3);
    logic [15:0] dims[4];
    dims = '{d0, d1, d2, d3};
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    foreach (dims[i]) begin
      write_dimension(dims[i]);
      repeat (130) send_random_item();
      drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_traffic(22, 88, 16'd1, 16'($urandom_range(12, 2)), 16'hFFFF,
                        16'($urandom_range(65534, 1001)));
    test_random_traffic(88, 22, 16'($urandom_range(12, 2)), 16'd0,
                        16'($urandom_range(1000, 13)), 16'hFFFF);
    test_random_traffic(0, 0, 16'd2, 16'($urandom_range(12, 2)),
                        16'($urandom_range(65534, 1001)), 16'hFFFF);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_fault($sformatf("%0d results never arrived", pending_results.size()));
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
